// ----- rtl/aes_pkg.sv -----
// AES-128 package: payload types, S-box, round constants and round helpers.
// Used by every module of the encryption block.
package aes_pkg;

  localparam int NumRounds = 10;

  typedef struct packed {
    logic [63:0] plain_upper;
    logic [63:0] plain_lower;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_upper;
    logic [63:0] cipher_lower;
  } aes_out_t;

  typedef struct packed {
    logic [7:0]   index;
    logic [63:0]  data;
  } aes_cfg_t;

  localparam logic [7:0] CfgKeyUpper = 8'd0;
  localparam logic [7:0] CfgKeyLower = 8'd1;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    case (r)
      4'd1:    return 8'h01;
      4'd2:    return 8'h02;
      4'd3:    return 8'h04;
      4'd4:    return 8'h08;
      4'd5:    return 8'h10;
      4'd6:    return 8'h20;
      4'd7:    return 8'h40;
      4'd8:    return 8'h80;
      4'd9:    return 8'h1b;
      4'd10:   return 8'h36;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte n sits at bits [127-8n -: 8].
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int n);
    return s[127-8*n -: 8];
  endfunction

endpackage

// ----- rtl/aes128_block_encrypt_top.sv -----
// AES-128 encryption top level: key registers, initial key addition and a row of round cells.
// Depends on aes_pkg and aes_cell.
//
// Usage:
//   cfg channel writes key_upper (index 0) and key_lower (index 1); other
//   indexes are dropped. Write the key only while the pipeline is empty.
//   in channel takes one plaintext item per cycle; out channel returns the
//   ciphertext item in the same order.
//   Pipeline: one input stage for the initial key addition, then one cell
//   per round, ten cells, between acceptance and out_valid_o.
//   Throughput: one item per cycle; the round key travels with the item
//   through the cell row, so no per-item key expansion stalls.
//   When the receiver stalls, the whole row holds; in_ready_o follows
//   out_ready_i or an empty last stage.
//   Reset clears the key to zero and empties the row.
module aes128_block_encrypt_top import aes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  aes_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aes_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aes_out_t out_o
);

  logic [63:0]  key_upper_q, key_lower_q;
  logic         en;
  logic         v0_q;
  logic [127:0] s0_q, k0_q;
  logic         v   [NumRounds+1];
  logic [127:0] s   [NumRounds+1];
  logic [127:0] k   [NumRounds+1];

  assign cfg_ready_o = 1'b1;
  assign en          = out_ready_i || !out_valid_o;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
      v0_q        <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_i.index == CfgKeyUpper) key_upper_q <= cfg_i.data;
      if (cfg_valid_i && cfg_i.index == CfgKeyLower) key_lower_q <= cfg_i.data;
      if (en) v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= {in_i.plain_upper, in_i.plain_lower} ^ {key_upper_q, key_lower_q};
      k0_q <= {key_upper_q, key_lower_q};
    end
  end

  assign v[0] = v0_q;
  assign s[0] = s0_q;
  assign k[0] = k0_q;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes_cell #(.Round(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[g-1]),
      .state_i (s[g-1]),
      .key_i   (k[g-1]),
      .valid_o (v[g]),
      .state_o (s[g]),
      .key_o   (k[g])
    );
  end

  assign out_valid_o        = v[NumRounds];
  assign out_o.cipher_upper = s[NumRounds][127:64];
  assign out_o.cipher_lower = s[NumRounds][63:0];

endmodule

// ----- rtl/aes_cell.sv -----
// One round cell: round transform of the state plus the next round key.
// Depends on aes_pkg.
module aes_cell import aes_pkg::*; #(
  parameter int Round = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  output logic         valid_o,
  output logic [127:0] state_o,
  output logic [127:0] key_o
);

  logic [127:0] key_d, sub_d, mix_d, state_d;
  logic [7:0]   sb [16];
  logic [31:0]  t;
  logic         valid_q;
  logic [127:0] state_q, key_q;

  always_comb begin
    t = {sbox(key_i[23:16]) ^ rcon(4'(Round)), sbox(key_i[15:8]), sbox(key_i[7:0]),
         sbox(key_i[31:24])};
    key_d[127:96] = key_i[127:96] ^ t;
    key_d[95:64]  = key_i[95:64] ^ key_d[127:96];
    key_d[63:32]  = key_i[63:32] ^ key_d[95:64];
    key_d[31:0]   = key_i[31:0] ^ key_d[63:32];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = sbox(byte_at(state_i, r + 4*((c + r) % 4)));
      end
    end
    for (int n = 0; n < 16; n++) begin
      sub_d[127-8*n -: 8] = sb[n];
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mix_d[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                               a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    state_d = ((Round == NumRounds) ? sub_d : mix_d) ^ key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

// ----- test/aes128_block_encrypt_top_tb.sv -----
// Testbench for aes128_block_encrypt_top: random and directed plaintext items under several keys,
// checked against an AES-128 cipher computed here. Depends on aes_pkg and the encryption RTL.
module aes128_block_encrypt_top_tb;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCycles = 400000;
  localparam int DrainCycles = 20;

  class cipher_board;
    aes_out_t pending_q[$];
    int errors;
    logic [127:0] key;

    function new();
      errors = 0;
      key = '0;
    endfunction

    function logic [7:0] sub_byte(logic [7:0] x);
      logic [7:0] tbl [256];
      tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return tbl[x];
    endfunction

    function logic [7:0] dbl(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function aes_out_t encrypt(aes_in_t pt);
      logic [7:0] rk [176];
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] w [4];
      logic [7:0] rc [10];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] blk;
      aes_out_t res;
      rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      blk = {pt.plain_upper, pt.plain_lower};
      for (int i = 0; i < 16; i++) begin
        rk[i] = key[127-8*i -: 8];
        st[i] = blk[127-8*i -: 8] ^ rk[i];
      end
      for (int i = 4; i < 44; i++) begin
        for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
        if (i % 4 == 0) begin
          a0 = w[0];
          w[0] = sub_byte(w[1]) ^ rc[i/4-1];
          w[1] = sub_byte(w[2]);
          w[2] = sub_byte(w[3]);
          w[3] = sub_byte(a0);
        end
        for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
      end
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int b = 0; b < 4; b++) tmp[b+4*c] = sub_byte(st[b+4*((c+b)%4)]);
        st = tmp;
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
            st[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
            st[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
            st[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[16*r+i];
      end
      for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = st[i];
      res.cipher_upper = blk[127:64];
      res.cipher_lower = blk[63:0];
      return res;
    endfunction

    function void set_key(logic [7:0] idx, logic [63:0] val);
      if (idx == CfgKeyUpper) key[127:64] = val;
      else if (idx == CfgKeyLower) key[63:0] = val;
    endfunction

    function void note_plain(aes_in_t pt);
      pending_q.push_back(encrypt(pt));
    endfunction

    function void check_cipher(aes_out_t got);
      aes_out_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected ciphertext %h", $time, got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.cipher_upper !== exp.cipher_upper) begin
        $display("%0t: cipher_upper expected %h actual %h", $time, exp.cipher_upper,
                 got.cipher_upper);
        errors++;
      end
      if (got.cipher_lower !== exp.cipher_lower) begin
        $display("%0t: cipher_lower expected %h actual %h", $time, exp.cipher_lower,
                 got.cipher_lower);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  aes_cfg_t cfg_i;
  logic     in_valid_i;
  logic     in_ready_o;
  aes_in_t  in_i;
  logic     out_valid_o;
  logic     out_ready_i;
  aes_out_t out_o;

  cipher_board board;
  int       cycle_count;
  int       blocks_sent;
  int       keys_loaded;
  bit       stall_long;

  aes128_block_encrypt_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_i,
    .in_valid_i,
    .in_ready_o,
    .in_i,
    .out_valid_o,
    .out_ready_i,
    .out_o
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    board = new();
    cycle_count = 0;
    stall_long = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_i = '0;
    in_valid_i = 1'b0;
    in_i = '0;
    out_ready_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_plain(in_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_cipher(out_o);
  end

  task automatic write_key(logic [7:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_i <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_key(idx, val);
    cfg_valid_i <= 1'b0;
    keys_loaded++;
  endtask

  task automatic send_block(logic [63:0] up, logic [63:0] lo, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_i <= '{plain_upper: up, plain_lower: lo};
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    blocks_sent++;
  endtask

  task automatic send_stream(int count, bit gaps);
    int gap;
    for (int n = 0; n < count; n++) begin
      gap = gaps ? $urandom_range(0, 17) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_i <= '{plain_upper: {$urandom, $urandom}, plain_lower: {$urandom, $urandom}};
      do @(posedge clk_i); while (!in_ready_o);
      blocks_sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : receiver
    int wait_n;
    @(posedge clk_i iff rst_ni === 1'b1);
    forever begin
      if (stall_long) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        stall_long = 0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
      end else begin
        wait_n = $urandom_range(0, 17);
        if (wait_n > 0) begin
          out_ready_i <= 1'b0;
          repeat (wait_n) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [63:0] keys_up [4];
    logic [63:0] keys_lo [4];
    blocks_sent = 0;
    keys_loaded = 0;
    keys_up = '{64'h2b7e151628aed2a6, 64'h0, 64'hffffffffffffffff, 64'h0};
    keys_lo = '{64'habf7158809cf4f3c, 64'h0, 64'hffffffffffffffff, 64'h0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset key of zero, extremes and a pattern with only the top and bottom bits set
    send_block(64'h0, 64'h0, 0);
    send_block(64'hffffffffffffffff, 64'hffffffffffffffff, 1);
    send_block(64'h8000000000000000, 64'h1, 1);
    wait_drain();
    write_key(8'd7, 64'hdeadbeefdeadbeef);
    write_key(8'hff, 64'h0123456789abcdef);
    send_block(64'h0, 64'h0, 0);
    wait_drain();
    for (int k = 0; k < 4; k++) begin
      if (k == 3) begin
        keys_up[3] = {$urandom, $urandom};
        keys_lo[3] = {$urandom, $urandom};
      end
      write_key(CfgKeyUpper, keys_up[k]);
      write_key(CfgKeyLower, keys_lo[k]);
      send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 0);
      send_block(64'h0, 64'hffffffffffffffff, 1);
      send_block(64'hffffffffffffffff, 64'h0, 1);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0);
      wait_drain();
    end
    write_key(CfgKeyLower, {$urandom, $urandom});
    stall_long = 1;
    send_stream(60, 0);
    wait_drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_key(CfgKeyUpper, {$urandom, $urandom});
      write_key(CfgKeyLower, {$urandom, $urandom});
      send_stream(115, ph % 2);
      wait_drain();
    end
    $display("ran %0d plaintext items under %0d key writes, with gaps, stalls and a long hold-off",
             blocks_sent, keys_loaded);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
